// ----- design/fsia_pkg.sv -----
// Shared types, constants and permutation tables for the six-index antisymmetrizer.
`default_nettype none
package fsia_pkg;

    // default sizes
    localparam int DEF_MAX_OCC    = 4;
    localparam int DEF_MAX_VIR    = 8;
    localparam int DEF_VALUE_BITS = 32;

    // growth of a 36-term signed sum
    localparam int SUM_GROWTH = 6;

    // fixed field widths
    localparam int OCC_W       = 2;
    localparam int VIR_W       = 3;
    localparam int OCC_CNT_W   = 3;
    localparam int VIR_CNT_W   = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OCC_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIR_COUNT = 1'd1;

    localparam logic [OCC_CNT_W-1:0] OCC_COUNT_RST = 3'd4;
    localparam logic [VIR_CNT_W-1:0] VIR_COUNT_RST = 4'd8;

    // commands
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // permutation counter
    localparam int               PERM_IDX_W = 3;
    localparam logic [PERM_IDX_W-1:0] PERM_FIRST = 3'd0;
    localparam logic [PERM_IDX_W-1:0] PERM_LAST  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic negate;
    } acc_ctl_t;

    // source slot for each destination slot of a triple, packed {n2, n1, n0}
    function automatic logic [5:0] perm_row(input logic [PERM_IDX_W-1:0] p);
        logic [5:0] row;
        case (p)
            3'd0:    row = {2'd2, 2'd1, 2'd0};
            3'd1:    row = {2'd0, 2'd2, 2'd1};
            3'd2:    row = {2'd1, 2'd0, 2'd2};
            3'd3:    row = {2'd2, 2'd0, 2'd1};
            3'd4:    row = {2'd1, 2'd2, 2'd0};
            3'd5:    row = {2'd0, 2'd1, 2'd2};
            default: row = {2'd2, 2'd1, 2'd0};
        endcase
        return row;
    endfunction

    function automatic logic perm_odd(input logic [PERM_IDX_W-1:0] p);
        logic odd;
        case (p)
            3'd3, 3'd4, 3'd5: odd = 1'b1;
            default:          odd = 1'b0;
        endcase
        return odd;
    endfunction

endpackage
`default_nettype wire

// ----- design/fsia_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fsia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/fsia_accum.sv -----
// Signed complex accumulator fed by the tensor memory read port.
`default_nettype none
module fsia_accum
    import fsia_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int SUM_BITS = VALUE_BITS + SUM_GROWTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire acc_ctl_t                ctl,
    input  wire logic [2*VALUE_BITS-1:0] rdata,
    output logic      [SUM_BITS-1:0]     sum_real,
    output logic      [SUM_BITS-1:0]     sum_imag
);

    localparam int EXT = SUM_BITS - VALUE_BITS;

    logic                valid_reg;
    logic                neg_reg;
    logic [SUM_BITS-1:0] acc_re_reg;
    logic [SUM_BITS-1:0] acc_im_reg;
    logic [SUM_BITS-1:0] term_re;
    logic [SUM_BITS-1:0] term_im;

    // align the sign with the registered memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.issue;
            neg_reg   <= ctl.negate;
        end
    end

    assign term_re = {{EXT{rdata[VALUE_BITS-1]}}, rdata[VALUE_BITS-1:0]};
    assign term_im = {{EXT{rdata[2*VALUE_BITS-1]}}, rdata[2*VALUE_BITS-1:VALUE_BITS]};

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (valid_reg)
        begin
            acc_re_reg <= neg_reg ? acc_re_reg - term_re : acc_re_reg + term_re;
            acc_im_reg <= neg_reg ? acc_im_reg - term_im : acc_im_reg + term_im;
        end
    end

    assign sum_real = acc_re_reg;
    assign sum_imag = acc_im_reg;

endmodule
`default_nettype wire

// ----- design/full_six_index_antisymmetrizer_unit.sv -----
// Top level: stores a six-index complex tensor and returns antisymmetrized elements.
// A store is taken while idle, one word per cycle, and gives no word unless out of range.
// A query issues 36 reads, one per cycle on the single memory read port, passes through
// the last state to the done state, loads its result there and then takes the next word.
// Out-of-range words go straight to the done state and load an error result; a stalled
// output holds the done state. Reset (rst_n, async, active low) clears control only.
`default_nettype none
module full_six_index_antisymmetrizer_unit
    import fsia_pkg::*;
#(
    parameter int MAX_OCC    = DEF_MAX_OCC,
    parameter int MAX_VIR    = DEF_MAX_VIR,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int SUM_BITS   = VALUE_BITS + SUM_GROWTH,
    localparam int IN_FLD_W   = 3 * OCC_W + 3 * VIR_W + 2 * VALUE_BITS,
    localparam int IN_DATA_W  = ((IN_FLD_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * SUM_BITS + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // s_tdata: occ_i, occ_j, occ_k, vir_a, vir_b, vir_c, value_real, value_imag
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // s_tuser: cmd
    input  wire logic                   s_tuser,
    // m_tdata: sum_real, sum_imag
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: index_error
    output logic                        m_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int STORE_DEPTH = MAX_OCC * MAX_OCC * MAX_OCC * MAX_VIR * MAX_VIR * MAX_VIR;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OLIM_W      = 5;
    localparam int VLIM_W      = 6;

    localparam logic [ADDR_W-1:0] OCC_MUL = ADDR_W'(MAX_OCC);
    localparam logic [ADDR_W-1:0] VIR_MUL = ADDR_W'(MAX_VIR);
    localparam logic [OLIM_W-1:0] OCC_MAX = OLIM_W'(MAX_OCC);
    localparam logic [VLIM_W-1:0] VIR_MAX = VLIM_W'(MAX_VIR);

    function automatic logic [ADDR_W-1:0] elem_addr(
        input logic [OCC_W-1:0] o0,
        input logic [OCC_W-1:0] o1,
        input logic [OCC_W-1:0] o2,
        input logic [VIR_W-1:0] v0,
        input logic [VIR_W-1:0] v1,
        input logic [VIR_W-1:0] v2
    );
        logic [ADDR_W-1:0] x;
        x = ADDR_W'(o0);
        x = ADDR_W'(x * OCC_MUL) + ADDR_W'(o1);
        x = ADDR_W'(x * OCC_MUL) + ADDR_W'(o2);
        x = ADDR_W'(x * VIR_MUL) + ADDR_W'(v0);
        x = ADDR_W'(x * VIR_MUL) + ADDR_W'(v1);
        x = ADDR_W'(x * VIR_MUL) + ADDR_W'(v2);
        return x;
    endfunction

    // input fields
    logic [OCC_W-1:0]      in_occ [3];
    logic [VIR_W-1:0]      in_vir [3];
    logic [VALUE_BITS-1:0] in_real;
    logic [VALUE_BITS-1:0] in_imag;

    assign in_occ[0] = s_tdata[1:0];
    assign in_occ[1] = s_tdata[3:2];
    assign in_occ[2] = s_tdata[5:4];
    assign in_vir[0] = s_tdata[8:6];
    assign in_vir[1] = s_tdata[11:9];
    assign in_vir[2] = s_tdata[14:12];
    assign in_real   = s_tdata[15 +: VALUE_BITS];
    assign in_imag   = s_tdata[15 + VALUE_BITS +: VALUE_BITS];

    // configuration
    logic [OCC_CNT_W-1:0] occ_count_reg;
    logic [VIR_CNT_W-1:0] vir_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_count_reg <= OCC_COUNT_RST;
            vir_count_reg <= VIR_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OCC_COUNT: occ_count_reg <= cfg_data[OCC_CNT_W-1:0];
                CFG_VIR_COUNT: vir_count_reg <= cfg_data[VIR_CNT_W-1:0];
                default:       occ_count_reg <= occ_count_reg;
            endcase
        end
    end

    // range check against saturated counts
    logic [OLIM_W-1:0] occ_lim;
    logic [VLIM_W-1:0] vir_lim;
    logic              in_bad;

    assign occ_lim = (OLIM_W'(occ_count_reg) > OCC_MAX) ? OCC_MAX : OLIM_W'(occ_count_reg);
    assign vir_lim = (VLIM_W'(vir_count_reg) > VIR_MAX) ? VIR_MAX : VLIM_W'(vir_count_reg);

    always_comb
    begin
        in_bad = 1'b0;
        for (int n = 0; n < 3; n++)
        begin
            if (OLIM_W'(in_occ[n]) >= occ_lim || VLIM_W'(in_vir[n]) >= vir_lim)
            begin
                in_bad = 1'b1;
            end
        end
    end

    // control state
    state_t                state_reg, state_next;
    logic [PERM_IDX_W-1:0] p_reg, p_next;
    logic [PERM_IDX_W-1:0] q_reg, q_next;
    logic                  err_reg, err_next;
    logic [OCC_W-1:0]      occ_reg [3];
    logic [VIR_W-1:0]      vir_reg [3];

    logic in_acc;
    logic out_free;
    logic pair_last;
    logic load_out;

    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign pair_last = (p_reg == PERM_LAST) && (q_reg == PERM_LAST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (s_tuser == CMD_QUERY)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (pair_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory and accumulator controls
    logic                    ram_we;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [2*VALUE_BITS-1:0] ram_rdata;
    acc_ctl_t                acc_ctl;
    logic [5:0]              row_o;
    logic [5:0]              row_v;

    assign row_o = perm_row(p_reg);
    assign row_v = perm_row(q_reg);

    always_comb
    begin
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load_out       = 1'b0;
        acc_ctl.clear  = 1'b0;
        acc_ctl.issue  = 1'b0;
        acc_ctl.negate = perm_odd(p_reg) ^ perm_odd(q_reg);
        p_next         = p_reg;
        q_next         = q_reg;
        err_next       = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_acc)
                begin
                    ram_we        = (s_tuser == CMD_STORE) && !in_bad;
                    acc_ctl.clear = 1'b1;
                    err_next      = in_bad;
                    p_next        = PERM_FIRST;
                    q_next        = PERM_FIRST;
                end
            end
            ST_READ:
            begin
                ram_re        = 1'b1;
                acc_ctl.issue = 1'b1;
                // advance the virtual permutation first, wrap into the occupied one
                if (q_reg == PERM_LAST)
                begin
                    q_next = PERM_FIRST;
                    p_next = p_reg + PERM_IDX_W'(1);
                end
                else
                begin
                    q_next = q_reg + PERM_IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                load_out = 1'b0;
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    assign ram_waddr = elem_addr(in_occ[0], in_occ[1], in_occ[2],
                                 in_vir[0], in_vir[1], in_vir[2]);
    assign ram_raddr = elem_addr(occ_reg[row_o[1:0]], occ_reg[row_o[3:2]],
                                 occ_reg[row_o[5:4]], vir_reg[row_v[1:0]],
                                 vir_reg[row_v[3:2]], vir_reg[row_v[5:4]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= PERM_FIRST;
            q_reg     <= PERM_FIRST;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            err_reg   <= err_next;
        end
    end

    // hold the query coordinates for the read sweep
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int n = 0; n < 3; n++)
            begin
                occ_reg[n] <= in_occ[n];
                vir_reg[n] <= in_vir[n];
            end
        end
    end

    fsia_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_imag, in_real}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [SUM_BITS-1:0] acc_real;
    logic [SUM_BITS-1:0] acc_imag;

    fsia_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (acc_ctl),
        .rdata    (ram_rdata),
        .sum_real (acc_real),
        .sum_imag (acc_imag)
    );

    // output register
    logic                out_valid_reg;
    logic [SUM_BITS-1:0] sum_real_reg;
    logic [SUM_BITS-1:0] sum_imag_reg;
    logic                index_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sum_real_reg    <= err_reg ? '0 : acc_real;
            sum_imag_reg    <= err_reg ? '0 : acc_imag;
            index_error_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({sum_imag_reg, sum_real_reg});
    assign m_tuser  = index_error_reg;

`ifndef SYNTHESIS
    // a clean query reaches the result stage after its full read sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == CMD_QUERY && !in_bad) |-> ##38 (state_reg == ST_DONE))
    else $error("query did not finish its read sweep on time");

    // a result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    else $error("result word appeared outside the done state");

    // a store never collides with a read of the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
    else $error("memory write during read sweep");
`endif

endmodule
`default_nettype wire
